FILE: hdl/bsu_pkg.sv
// ----------------------------------------------------------------------------
// bsu_pkg
// Shared types and codes for the branch and stack unit: instruction modes,
// condition codes, the registered instruction request and one result beat.
// ----------------------------------------------------------------------------
package bsu_pkg;

	typedef enum logic [3:0] {
		MODE_CALL    = 4'd0,
		MODE_CALL_CC = 4'd1,
		MODE_JP_HL   = 4'd2,
		MODE_JP      = 4'd3,
		MODE_JP_CC   = 4'd4,
		MODE_JR      = 4'd5,
		MODE_JR_CC   = 4'd6,
		MODE_RET     = 4'd7,
		MODE_RET_CC  = 4'd8,
		MODE_RETI    = 4'd9,
		MODE_RST     = 4'd10,
		MODE_POP     = 4'd11,
		MODE_PUSH    = 4'd12
	} mode_t;

	typedef enum logic [1:0] {
		COND_NZ = 2'd0,
		COND_NC = 2'd1,
		COND_Z  = 2'd2,
		COND_C  = 2'd3
	} cond_t;

	// Beat number within one request: two stack writes, then the final beat.
	typedef logic [1:0] beat_t;
	localparam beat_t BEAT_WR_HI = 2'd0;
	localparam beat_t BEAT_WR_LO = 2'd1;
	localparam beat_t BEAT_FINAL = 2'd2;

	typedef struct packed {
		logic [3:0]  mode;
		logic [1:0]  cond;
		logic        flag_z;
		logic        flag_c;
		logic [15:0] pc_in;
		logic [15:0] sp_in;
		logic [15:0] hl_value;
		logic [15:0] operand;
		logic [7:0]  vector;
		logic [15:0] push_value;
		logic [15:0] stack_word;
	} req_t;

	typedef struct packed {
		logic        is_write;
		logic [15:0] write_addr;
		logic [7:0]  write_data;
		logic [15:0] new_pc;
		logic [15:0] new_sp;
		logic [15:0] popped_value;
		logic        ime_enable;
		logic [2:0]  machine_cycles;
		logic        last;
	} result_t;

endpackage

FILE: hdl/bsu_decode.sv
// ----------------------------------------------------------------------------
// bsu_decode
// Combinational execution of one registered request: forms the result beat
// selected by the beat number, either a stack byte write or the final beat.
// ----------------------------------------------------------------------------
module bsu_decode (
	input  bsu_pkg::req_t    req,
	input  bsu_pkg::beat_t   beat,
	output bsu_pkg::result_t res
);
	import bsu_pkg::*;

	logic        cond_ok;
	logic        pushes;
	logic [15:0] push_word;
	logic [15:0] pc1;
	logic [15:0] pc2;
	logic [15:0] sp_m1;
	logic [15:0] sp_m2;
	logic [15:0] sp_p2;
	logic [15:0] rel_off;
	logic        write_beat;
	result_t     fin;

	always_comb begin
		unique case (cond_t'(req.cond))
			COND_NZ: cond_ok = !req.flag_z;
			COND_NC: cond_ok = !req.flag_c;
			COND_Z:  cond_ok = req.flag_z;
			COND_C:  cond_ok = req.flag_c;
			default: cond_ok = 1'b0;
		endcase
	end

	assign pc1     = req.pc_in + 16'd1;
	assign pc2     = req.pc_in + 16'd2;
	assign sp_m1   = req.sp_in - 16'd1;
	assign sp_m2   = req.sp_in - 16'd2;
	assign sp_p2   = req.sp_in + 16'd2;
	assign rel_off = {{8{req.operand[7]}}, req.operand[7:0]};

	// Final beat and the word that goes to the stack, if any.
	always_comb begin
		fin           = '0;
		fin.last      = 1'b1;
		fin.new_pc    = req.pc_in;
		fin.new_sp    = req.sp_in;
		pushes        = 1'b0;
		push_word     = req.pc_in;
		unique case (req.mode)
			MODE_CALL, MODE_CALL_CC: begin
				if (req.mode == MODE_CALL || cond_ok) begin
					pushes             = 1'b1;
					push_word          = pc2;
					fin.new_pc         = req.operand;
					fin.new_sp         = sp_m2;
					fin.machine_cycles = 3'd6;
				end else begin
					fin.new_pc         = pc2;
					fin.machine_cycles = 3'd3;
				end
			end
			MODE_JP_HL: begin
				fin.new_pc         = req.hl_value;
				fin.machine_cycles = 3'd1;
			end
			MODE_JP, MODE_JP_CC: begin
				if (req.mode == MODE_JP || cond_ok) begin
					fin.new_pc         = req.operand;
					fin.machine_cycles = 3'd4;
				end else begin
					fin.new_pc         = pc2;
					fin.machine_cycles = 3'd3;
				end
			end
			MODE_JR, MODE_JR_CC: begin
				if (req.mode == MODE_JR || cond_ok) begin
					fin.new_pc         = pc1 + rel_off;
					fin.machine_cycles = 3'd3;
				end else begin
					fin.new_pc         = pc1;
					fin.machine_cycles = 3'd2;
				end
			end
			MODE_RET: begin
				fin.new_pc         = req.stack_word;
				fin.new_sp         = sp_p2;
				fin.machine_cycles = 3'd4;
			end
			MODE_RET_CC: begin
				if (cond_ok) begin
					fin.new_pc         = req.stack_word;
					fin.new_sp         = sp_p2;
					fin.machine_cycles = 3'd5;
				end else begin
					fin.machine_cycles = 3'd2;
				end
			end
			MODE_RETI: begin
				fin.new_pc         = req.stack_word;
				fin.new_sp         = sp_p2;
				fin.ime_enable     = 1'b1;
				fin.machine_cycles = 3'd4;
			end
			MODE_RST: begin
				pushes             = 1'b1;
				push_word          = req.pc_in;
				fin.new_pc         = {8'h00, req.vector};
				fin.new_sp         = sp_m2;
				fin.machine_cycles = 3'd4;
			end
			MODE_POP: begin
				fin.new_sp         = sp_p2;
				fin.popped_value   = req.stack_word;
				fin.machine_cycles = 3'd3;
			end
			MODE_PUSH: begin
				pushes             = 1'b1;
				push_word          = req.push_value;
				fin.new_sp         = sp_m2;
				fin.machine_cycles = 3'd4;
			end
			default: begin
				// Undefined modes behave as a no-op with machine_cycles set to 1.
				fin.machine_cycles = 3'd1;
			end
		endcase
	end

	assign write_beat = pushes && (beat != BEAT_FINAL);

	always_comb begin
		if (write_beat) begin
			res          = '0;
			res.is_write = 1'b1;
			if (beat == BEAT_WR_HI) begin
				res.write_addr = sp_m1;
				res.write_data = push_word[15:8];
			end else begin
				res.write_addr = sp_m2;
				res.write_data = push_word[7:0];
			end
		end else begin
			res = fin;
		end
	end

endmodule

FILE: hdl/branch_and_stack_unit.sv
// ----------------------------------------------------------------------------
// branch_and_stack_unit
// Executes one control-flow or stack instruction per request and streams the
// resulting stack byte writes followed by a final PC/SP result.
// ----------------------------------------------------------------------------
// A request is taken on a rising edge where start is high and busy is low.
// It is registered, and its results then leave the result register one per
// cycle, each valid for exactly one cycle while done is high; the receiver
// cannot stall them, so it must capture every cycle that done is high.
// Instructions that push (taken call, rst, push) give three results: the
// high byte written at sp-1, the low byte written at sp-2, then the final
// result with last high. All other instructions give only the final result.
// Throughput is one request per cycle for single-result instructions; a
// pushing one holds busy high until its final beat is formed, since the
// single result port carries one beat per cycle. Between acceptance and
// the first result lie the request register, then the result register.
// Nothing is carried between requests, so a new request is taken in the
// same cycle that the previous request's final beat is formed.
module branch_and_stack_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [3:0]  mode,
	input  logic [1:0]  cond,
	input  logic        flag_z,
	input  logic        flag_c,
	input  logic [15:0] pc_in,
	input  logic [15:0] sp_in,
	input  logic [15:0] hl_value,
	input  logic [15:0] operand,
	input  logic [7:0]  vector,
	input  logic [15:0] push_value,
	input  logic [15:0] stack_word,
	output logic        done,
	output logic        is_write,
	output logic [15:0] write_addr,
	output logic [7:0]  write_data,
	output logic [15:0] new_pc,
	output logic [15:0] new_sp,
	output logic [15:0] popped_value,
	output logic        ime_enable,
	output logic [2:0]  machine_cycles,
	output logic        last
);
	import bsu_pkg::*;

	// Registered request and the beat that is formed from it this cycle.
	req_t    req_s1;
	logic    valid_s1;
	beat_t   beat_q;

	result_t beat_res;
	result_t res_q;
	logic    done_q;

	logic    accept;
	logic    final_now;

	bsu_decode u_decode (
		.req  (req_s1),
		.beat (beat_q),
		.res  (beat_res)
	);

	// The request register frees up in the cycle its final beat is formed.
	assign final_now = valid_s1 && beat_res.last;
	assign busy      = valid_s1 && !final_now;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			beat_q   <= BEAT_WR_HI;
			done_q   <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				beat_q   <= BEAT_WR_HI;
			end else if (final_now) begin
				valid_s1 <= 1'b0;
				beat_q   <= BEAT_WR_HI;
			end else if (valid_s1) begin
				// Only write beats get here; step to the next beat.
				beat_q <= beat_q + 2'd1;
			end
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.mode       <= mode;
			req_s1.cond       <= cond;
			req_s1.flag_z     <= flag_z;
			req_s1.flag_c     <= flag_c;
			req_s1.pc_in      <= pc_in;
			req_s1.sp_in      <= sp_in;
			req_s1.hl_value   <= hl_value;
			req_s1.operand    <= operand;
			req_s1.vector     <= vector;
			req_s1.push_value <= push_value;
			req_s1.stack_word <= stack_word;
		end
		if (valid_s1) begin
			res_q <= beat_res;
		end
	end

	assign done           = done_q;
	assign is_write       = res_q.is_write;
	assign write_addr     = res_q.write_addr;
	assign write_data     = res_q.write_data;
	assign new_pc         = res_q.new_pc;
	assign new_sp         = res_q.new_sp;
	assign popped_value   = res_q.popped_value;
	assign ime_enable     = res_q.ime_enable;
	assign machine_cycles = res_q.machine_cycles;
	assign last           = res_q.last;

endmodule
